// File: rtl/core/mqm_pkg.sv
// Shared types and constants for the max_queue_monotonic block.
// Holds the request and response structs, operation and status codes.
// No dependencies.
package mqm_pkg;

    localparam int MQM_CAPACITY    = 64;
    localparam int MQM_VALUE_WIDTH = 32;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_POP_EMPTY  = 2'd1;
    localparam logic [1:0] STATUS_PUSH_FULL  = 2'd2;

    typedef struct packed {
        logic               op;
        logic signed [31:0] value;
    } mqm_req_t;

    typedef struct packed {
        logic signed [31:0] max_value;
        logic [6:0]         item_total;
        logic               is_empty;
        logic [1:0]         status;
    } mqm_rsp_t;

endpackage

// File: rtl/core/max_queue_monotonic.sv
// Top level of the max_queue_monotonic block: a FIFO that reports its maximum.
// Candidates live in two synchronous memories (values and skip counts).
// Depends on mqm_pkg.

// A transaction is taken when start is high and busy is low; its response
// appears on response for exactly one cycle with done high, and the receiver
// cannot stall it. Each operation passes through EXEC, plus one state per
// memory read it needs: a pop that retires the front candidate and leaves
// others adds LOAD for the new front, and a push onto a non-empty list takes
// one CMP step per candidate examined, ending at one that is not smaller
// or when it clears the list. The back-walk of a push is the bound: each
// step waits on one read of the candidate memories. Because every candidate
// is removed at most once, pushes average about one walk step each. busy
// drops in the same cycle that done is high, so the next transaction can
// be issued then. The memories need no clearing after reset.
module max_queue_monotonic
    import mqm_pkg::*;
#(
    parameter int CAPACITY    = MQM_CAPACITY,
    parameter int VALUE_WIDTH = MQM_VALUE_WIDTH
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  mqm_req_t request,
    output logic     busy,
    output logic     done,
    output mqm_rsp_t response
);

    localparam int PTR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(CAPACITY);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_EXEC = 4'b0010,
        ST_CMP  = 4'b0100,
        ST_LOAD = 4'b1000
    } state_t;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + PTR_W'(1);
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_LAST : p - PTR_W'(1);
    endfunction

    // Candidate memories.
    logic [VALUE_WIDTH-1:0] val_mem [CAPACITY];
    logic [CNT_W-1:0]       skip_mem [CAPACITY];

    state_t                 state_reg, state_next;
    logic                   op_reg;
    logic [VALUE_WIDTH-1:0] val_reg;
    logic [PTR_W-1:0]       head_reg, head_next;
    logic [PTR_W-1:0]       tail_reg, tail_next;
    logic [CNT_W-1:0]       cand_reg, cand_next;
    logic [CNT_W-1:0]       item_reg, item_next;
    logic [CNT_W-1:0]       acc_reg, acc_next;
    logic [VALUE_WIDTH-1:0] front_val_reg, front_val_next;
    logic [CNT_W-1:0]       front_skip_reg, front_skip_next;
    logic                   done_reg, done_next;
    mqm_rsp_t               result_reg, result_next;

    logic [PTR_W-1:0]       rd_addr;
    logic [VALUE_WIDTH-1:0] rd_val_reg;
    logic [CNT_W-1:0]       rd_skip_reg;
    logic                   val_we, skip_we;
    logic [PTR_W-1:0]       wr_addr;
    logic [VALUE_WIDTH-1:0] wr_val;
    logic [CNT_W-1:0]       wr_skip;

    logic                   accept;
    logic                   greater;
    logic [CNT_W-1:0]       acc_sum;
    logic [PTR_W-1:0]       tail_dec;
    logic [CNT_W-1:0]       cand_dec;
    logic [1:0]             status_code;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign done   = done_reg;
    assign response = result_reg;

    assign greater  = $signed(val_reg) > $signed(rd_val_reg);
    assign acc_sum  = acc_reg + rd_skip_reg + CNT_ONE;
    assign tail_dec = ptr_dec(tail_reg);
    assign cand_dec = cand_reg - CNT_ONE;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        cand_next       = cand_reg;
        item_next       = item_reg;
        acc_next        = acc_reg;
        front_val_next  = front_val_reg;
        front_skip_next = front_skip_reg;
        done_next       = 1'b0;
        status_code     = STATUS_OK;
        rd_addr         = tail_dec;
        val_we          = 1'b0;
        skip_we         = 1'b0;
        wr_addr         = tail_reg;
        wr_val          = val_reg;
        wr_skip         = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (op_reg == OP_PUSH)
                begin
                    if (item_reg >= CNT_FULL)
                    begin
                        status_code = STATUS_PUSH_FULL;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else if (cand_reg == '0)
                    begin
                        val_we          = 1'b1;
                        skip_we         = 1'b1;
                        tail_next       = ptr_inc(tail_reg);
                        cand_next       = CNT_ONE;
                        item_next       = item_reg + CNT_ONE;
                        front_val_next  = val_reg;
                        front_skip_next = '0;
                        done_next       = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        // Read the back candidate; the walk starts next cycle.
                        rd_addr    = tail_dec;
                        acc_next   = '0;
                        state_next = ST_CMP;
                    end
                end
                else
                begin
                    if (item_reg == '0 || cand_reg == '0)
                    begin
                        status_code = STATUS_POP_EMPTY;
                        done_next   = 1'b1;
                        state_next  = ST_IDLE;
                    end
                    else if (front_skip_reg != '0)
                    begin
                        skip_we         = 1'b1;
                        wr_addr         = head_reg;
                        wr_skip         = front_skip_reg - CNT_ONE;
                        front_skip_next = front_skip_reg - CNT_ONE;
                        item_next       = item_reg - CNT_ONE;
                        done_next       = 1'b1;
                        state_next      = ST_IDLE;
                    end
                    else
                    begin
                        head_next = ptr_inc(head_reg);
                        cand_next = cand_dec;
                        item_next = item_reg - CNT_ONE;
                        rd_addr   = ptr_inc(head_reg);
                        if (cand_dec != '0)
                        begin
                            state_next = ST_LOAD;
                        end
                        else
                        begin
                            done_next  = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_CMP:
            begin
                item_next = item_reg;
                if (greater)
                begin
                    if (cand_dec != '0)
                    begin
                        // Drop this candidate and fetch the one before it.
                        tail_next = tail_dec;
                        cand_next = cand_dec;
                        acc_next  = acc_sum;
                        rd_addr   = ptr_dec(tail_dec);
                    end
                    else
                    begin
                        // The whole list was smaller: the new value is the front.
                        val_we          = 1'b1;
                        skip_we         = 1'b1;
                        wr_addr         = tail_dec;
                        wr_skip         = acc_sum;
                        tail_next       = tail_reg;
                        cand_next       = CNT_ONE;
                        item_next       = item_reg + CNT_ONE;
                        front_val_next  = val_reg;
                        front_skip_next = acc_sum;
                        done_next       = 1'b1;
                        state_next      = ST_IDLE;
                    end
                end
                else
                begin
                    val_we     = 1'b1;
                    skip_we    = 1'b1;
                    wr_addr    = tail_reg;
                    wr_skip    = acc_reg;
                    tail_next  = ptr_inc(tail_reg);
                    cand_next  = cand_reg + CNT_ONE;
                    item_next  = item_reg + CNT_ONE;
                    done_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_LOAD:
            begin
                front_val_next  = rd_val_reg;
                front_skip_next = rd_skip_reg;
                done_next       = 1'b1;
                state_next      = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        result_next.max_value  = (item_next != '0 && cand_next != '0)
                                 ? 32'(front_val_next) : '0;
        result_next.item_total = 7'(item_next);
        result_next.is_empty   = (item_next == '0);
        result_next.status     = status_code;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            head_reg  <= '0;
            tail_reg  <= '0;
            cand_reg  <= '0;
            item_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            cand_reg  <= cand_next;
            item_reg  <= item_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg  <= request.op;
            val_reg <= VALUE_WIDTH'($unsigned(request.value));
        end
        acc_reg        <= acc_next;
        front_val_reg  <= front_val_next;
        front_skip_reg <= front_skip_next;
        result_reg     <= result_next;
    end

    always_ff @(posedge clk)
    begin
        if (val_we)
        begin
            val_mem[wr_addr] <= wr_val;
        end
        if (skip_we)
        begin
            skip_mem[wr_addr] <= wr_skip;
        end
        rd_val_reg  <= val_mem[rd_addr];
        rd_skip_reg <= skip_mem[rd_addr];
    end

endmodule
